// ===== rtl/lvsm_pkg.sv =====
// ----------------------------------------------------------------------------
// lvsm_pkg
// Types and constants of the logical volume sector mapper: field widths,
// stream packing offsets, item kinds and register reset values.
// ----------------------------------------------------------------------------
package lvsm_pkg;

  localparam int SEGMENT_ENTRIES_DEFAULT = 16;
  localparam int SEGMENT_ENTRIES_MAX     = 256;

  localparam int INDEX_W   = 4;
  localparam int EXTENT_W  = 32;
  localparam int SECTOR_W  = 64;
  localparam int SHIFT_W   = 5;

  localparam logic [SHIFT_W-1:0] EXTENT_SHIFT_RESET = 5'd13;

  // Input tdata layout, lowest bit first.
  localparam int IN_INDEX_LSB   = 0;
  localparam int IN_FIRST_LSB   = IN_INDEX_LSB + INDEX_W;
  localparam int IN_TOTAL_LSB   = IN_FIRST_LSB + EXTENT_W;
  localparam int IN_BASE_LSB    = IN_TOTAL_LSB + EXTENT_W;
  localparam int IN_STRIPE_LSB  = IN_BASE_LSB + SECTOR_W;
  localparam int IN_LOGICAL_LSB = IN_STRIPE_LSB + EXTENT_W;
  localparam int IN_USED_W      = IN_LOGICAL_LSB + SECTOR_W;
  localparam int IN_TDATA_W     = ((IN_USED_W + 7) / 8) * 8;

  localparam int OUT_TDATA_W = SECTOR_W;

  typedef enum logic {
    KIND_LOAD      = 1'b0,
    KIND_TRANSLATE = 1'b1
  } kind_t;

endpackage

// ===== rtl/logical_volume_sector_mapper.sv =====
// ----------------------------------------------------------------------------
// logical_volume_sector_mapper
// Maps logical volume sectors to physical disk sectors through a small
// table of linear segments.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries items. tuser is the kind: a load item writes one
// segment entry (first extent, extent count, base sector, stripe extent) and
// gives no result; a translate item gives one result on the master stream,
// the physical sector in tdata and the hit flag in tuser.
// The cfg channel writes extent_shift (log2 of sectors per extent); it is
// always ready, and the user must write it only while the block is idle:
// the block itself does not enforce this. The pipeline has four register
// stages: sector split, segment match and select, extent add, shift and
// final add. One item is accepted every cycle while the receiver takes
// results. Loads update the table as they leave the first stage, so items
// see loads in order. Reset clears the pipeline valid bits and the
// per-entry valid bits, and extent_shift returns to 13. When the receiver
// stalls, results hold in the output stage and earlier stages fill up,
// closing any bubbles, before s_tready drops.
// ----------------------------------------------------------------------------
module logical_volume_sector_mapper #(
  parameter int SEGMENT_ENTRIES = lvsm_pkg::SEGMENT_ENTRIES_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Bits from 0: entry_index[4], first_extent[32], extent_total[32],
  // base_sector[64], stripe_extent[32], logical_sector[64], zero padding.
  input  logic [lvsm_pkg::IN_TDATA_W-1:0]   s_tdata,
  // Bit 0: kind.
  input  logic                              s_tuser,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Bits from 0: physical_sector[64].
  output logic [lvsm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // Bit 0: hit.
  output logic                              m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [lvsm_pkg::SHIFT_W-1:0]      cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);

  localparam int EW  = lvsm_pkg::EXTENT_W;
  localparam int SW  = lvsm_pkg::SECTOR_W;
  localparam int IXW = 9;  // wide enough to compare with any table depth

  // Configuration register.
  logic [lvsm_pkg::SHIFT_W-1:0] extent_shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_shift <= lvsm_pkg::EXTENT_SHIFT_RESET;
    end else if (cfg_valid) begin
      extent_shift <= cfg_data;
    end
  end

  // Segment table.
  logic [EW-1:0]         seg_first  [SEGMENT_ENTRIES];
  logic [EW-1:0]         seg_length [SEGMENT_ENTRIES];
  logic [SW-1:0]         seg_base   [SEGMENT_ENTRIES];
  logic [EW-1:0]         seg_stripe [SEGMENT_ENTRIES];
  logic [SEGMENT_ENTRIES-1:0] seg_valid;

  // Pipeline valid bits and stage enables.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1 payload.
  logic                  load1;
  logic                  idx_ok1;
  logic [lvsm_pkg::INDEX_W-1:0] idx1;
  logic [EW-1:0]         first1, total1, stripe1;
  logic [SW-1:0]         base1;
  logic [SW-1:0]         extent1, offset1;

  // Stage 2 payload.
  logic                  hit2;
  logic [SEGMENT_ENTRIES-1:0] sel2;
  logic [EW-1:0]         diff2, stripe2;
  logic [SW-1:0]         base2, offset2;

  // Stage 3 payload.
  logic                  hit3;
  logic [EW:0]           rel3;
  logic [SW-1:0]         bo3;

  // Output stage.
  logic                  hit4;
  logic [SW-1:0]         phys4;

  // A load in stage 1 always leaves at the next edge: it only writes the table.
  assign rdy4 = !v4 || m_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || load1 || rdy2;
  assign s_tready = rdy1;

  // Stage 0 -> 1: split the sector into extent number and offset.
  logic [SW-1:0] in_sector;
  logic [IXW-1:0] in_idx_ext;

  assign in_sector  = s_tdata[lvsm_pkg::IN_LOGICAL_LSB +: SW];
  assign in_idx_ext = {{(IXW-lvsm_pkg::INDEX_W){1'b0}},
                       s_tdata[lvsm_pkg::IN_INDEX_LSB +: lvsm_pkg::INDEX_W]};

  // Stage 1 -> 2: match every entry, keep the lowest-numbered hit.
  logic                       tbl_we;
  logic [IXW-1:0]             idx1_ext;
  logic [SW:0]                sub      [SEGMENT_ENTRIES];
  logic [SEGMENT_ENTRIES-1:0] match;
  logic [SEGMENT_ENTRIES-1:0] onehot;
  logic [EW-1:0]              sel_diff, sel_stripe;
  logic [SW-1:0]              sel_base;

  assign tbl_we   = v1 && load1 && idx_ok1;
  assign idx1_ext = {{(IXW-lvsm_pkg::INDEX_W){1'b0}}, idx1};

  always_comb begin
    for (int e = 0; e < SEGMENT_ENTRIES; e++) begin
      sub[e]   = {1'b0, extent1} - {{(SW-EW+1){1'b0}}, seg_first[e]};
      match[e] = seg_valid[e] && !sub[e][SW] && (sub[e][SW-1:EW] == '0) &&
                 (sub[e][EW-1:0] < seg_length[e]);
    end
  end

  // Isolate the lowest set bit of the match vector.
  assign onehot = match & (~match + SEGMENT_ENTRIES'(1));

  always_comb begin
    sel_diff   = '0;
    sel_stripe = '0;
    sel_base   = '0;
    for (int e = 0; e < SEGMENT_ENTRIES; e++) begin
      sel_diff   = sel_diff   | ({EW{onehot[e]}} & sub[e][EW-1:0]);
      sel_stripe = sel_stripe | ({EW{onehot[e]}} & seg_stripe[e]);
      sel_base   = sel_base   | ({SW{onehot[e]}} & seg_base[e]);
    end
  end

  // Final add, with the miss forced to zero.
  logic [SW-1:0] phys_next;

  always_comb begin
    if (hit3) begin
      phys_next = ({{(SW-EW-1){1'b0}}, rel3} << extent_shift) + bo3;
    end else begin
      phys_next = '0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      seg_valid <= '0;
    end else begin
      if (rdy1) begin
        v1 <= s_tvalid;
      end
      if (rdy2) begin
        v2 <= v1 && !load1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
      for (int e = 0; e < SEGMENT_ENTRIES; e++) begin
        if (tbl_we && idx1_ext == IXW'(e)) begin
          seg_valid[e] <= 1'b1;
        end
      end
    end
  end

  // Table payload.
  always_ff @(posedge clk) begin
    for (int e = 0; e < SEGMENT_ENTRIES; e++) begin
      if (tbl_we && idx1_ext == IXW'(e)) begin
        seg_first[e]  <= first1;
        seg_length[e] <= total1;
        seg_base[e]   <= base1;
        seg_stripe[e] <= stripe1;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      load1   <= (s_tuser == lvsm_pkg::KIND_LOAD);
      idx1    <= s_tdata[lvsm_pkg::IN_INDEX_LSB +: lvsm_pkg::INDEX_W];
      idx_ok1 <= (in_idx_ext < IXW'(SEGMENT_ENTRIES));
      first1  <= s_tdata[lvsm_pkg::IN_FIRST_LSB +: EW];
      total1  <= s_tdata[lvsm_pkg::IN_TOTAL_LSB +: EW];
      base1   <= s_tdata[lvsm_pkg::IN_BASE_LSB +: SW];
      stripe1 <= s_tdata[lvsm_pkg::IN_STRIPE_LSB +: EW];
      extent1 <= in_sector >> extent_shift;
      offset1 <= in_sector & ~({SW{1'b1}} << extent_shift);
    end
    if (rdy2) begin
      hit2    <= |match;
      sel2    <= onehot;
      diff2   <= sel_diff;
      stripe2 <= sel_stripe;
      base2   <= sel_base;
      offset2 <= offset1;
    end
    if (rdy3) begin
      hit3 <= hit2;
      rel3 <= {1'b0, stripe2} + {1'b0, diff2};
      bo3  <= base2 + offset2;
    end
    if (rdy4) begin
      hit4  <= hit3;
      phys4 <= phys_next;
    end
  end

  assign m_tvalid = v4;
  assign m_tdata  = phys4;
  assign m_tuser  = hit4;

  // A miss must come out as sector zero.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss result carries a nonzero sector");

  // At most one entry is selected, and a hit has exactly one.
  assert property (@(posedge clk) disable iff (rst) v2 |-> $onehot0(sel2) && (hit2 == |sel2))
    else $error("segment select is not one-hot with the hit flag");

  // Input backpressure only comes from a translate held in stage one.
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> v1 && !load1 && v2)
    else $error("input stalled without a full pipeline");

  // Reset leaves every table entry unused.
  assert property (@(posedge clk) rst |=> seg_valid == '0)
    else $error("segment valid bits not cleared by reset");

  // An entry becomes valid only through a load leaving stage one.
  assert property (@(posedge clk) disable iff (rst)
                   (seg_valid != $past(seg_valid)) |-> $past(tbl_we))
    else $error("segment table changed without a load");

endmodule
